/* design/vrot_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vrot_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int ANGLE_WIDTH   = 32;
  localparam int CORDIC_STAGES = 24;
  localparam int GUARD_BITS    = 8;

  localparam int TURN_WIDTH = 32;
  localparam int Z_WIDTH    = 32;
  localparam int MUL_SPLIT  = 32;

  // guard bits plus headroom for the quadrant negation and the CORDIC gain
  localparam int DATA_WIDTH = (COORD_WIDTH + GUARD_BITS + 3 > MUL_SPLIT + 1) ?
                              (COORD_WIDTH + GUARD_BITS + 3) : (MUL_SPLIT + 1);
  localparam int HI_WIDTH   = DATA_WIDTH - MUL_SPLIT;
  localparam int PH_WIDTH   = HI_WIDTH + MUL_SPLIT;
  localparam int SUM_WIDTH  = DATA_WIDTH + 1;
  localparam int RND_WIDTH  = SUM_WIDTH - GUARD_BITS;

  localparam logic [MUL_SPLIT-1:0]  INV_GAIN     = 32'd2608131496;
  localparam logic [TURN_WIDTH-1:0] QUARTER_HALF = 32'h2000_0000;

  localparam logic [1:0] ACT_X    = 2'd0;
  localparam logic [1:0] ACT_Y    = 2'd1;
  localparam logic [1:0] ACT_Z    = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DATA_WIDTH-1:0]  data_t;
  typedef logic signed [Z_WIDTH-1:0]     zang_t;

  typedef struct packed {
    logic [1:0] action;
    coord_t     x;
    coord_t     y;
    coord_t     z;
  } side_t;

  typedef struct packed {
    data_t u;
    data_t v;
    zang_t z;
  } rot_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [Z_WIDTH-1:0] atan_turn(input logic [4:0] idx);
    logic [Z_WIDTH-1:0] res;
    case (idx)
      5'd0:    res = 32'd536870912;
      5'd1:    res = 32'd316933406;
      5'd2:    res = 32'd167458907;
      5'd3:    res = 32'd85004756;
      5'd4:    res = 32'd42667331;
      5'd5:    res = 32'd21354465;
      5'd6:    res = 32'd10679838;
      5'd7:    res = 32'd5340245;
      5'd8:    res = 32'd2670163;
      5'd9:    res = 32'd1335087;
      5'd10:   res = 32'd667544;
      5'd11:   res = 32'd333772;
      5'd12:   res = 32'd166886;
      5'd13:   res = 32'd83443;
      5'd14:   res = 32'd41722;
      5'd15:   res = 32'd20861;
      5'd16:   res = 32'd10430;
      5'd17:   res = 32'd5215;
      5'd18:   res = 32'd2608;
      5'd19:   res = 32'd1304;
      5'd20:   res = 32'd652;
      5'd21:   res = 32'd326;
      5'd22:   res = 32'd163;
      5'd23:   res = 32'd81;
      5'd24:   res = 32'd41;
      5'd25:   res = 32'd20;
      5'd26:   res = 32'd10;
      5'd27:   res = 32'd5;
      5'd28:   res = 32'd3;
      5'd29:   res = 32'd1;
      5'd30:   res = 32'd1;
      default: res = 32'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/vrot_prep.sv */
`timescale 1ns / 1ps
`default_nettype none

module vrot_prep (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic [1:0]                         in_action,
  input  wire vrot_pkg::coord_t                   in_x,
  input  wire vrot_pkg::coord_t                   in_y,
  input  wire vrot_pkg::coord_t                   in_z,
  input  wire logic [vrot_pkg::ANGLE_WIDTH-1:0]   in_turn_angle,
  output logic                                    valid_r,
  output vrot_pkg::rot_t                          rot_r,
  output vrot_pkg::side_t                         side_r
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic [vrot_pkg::TURN_WIDTH-1:0] turn;
  logic [vrot_pkg::TURN_WIDTH-1:0] turn_off;
  logic [1:0]                      quad;
  logic [vrot_pkg::TURN_WIDTH-1:0] resid;
  vrot_pkg::coord_t                u0;
  vrot_pkg::coord_t                v0;
  vrot_pkg::data_t                 ug;
  vrot_pkg::data_t                 vg;
  vrot_pkg::rot_t                  rot_nxt;
  vrot_pkg::side_t                 side_nxt;

  always_comb begin
    turn     = vrot_pkg::TURN_WIDTH'(in_turn_angle)
               << (vrot_pkg::TURN_WIDTH - vrot_pkg::ANGLE_WIDTH);
    turn_off = turn + vrot_pkg::QUARTER_HALF;
    quad     = turn_off[vrot_pkg::TURN_WIDTH-1 -: 2];
    resid    = turn - (vrot_pkg::TURN_WIDTH'(quad) << (vrot_pkg::TURN_WIDTH - 2));

    case (in_action)
      vrot_pkg::ACT_X: begin
        u0 = in_y;
        v0 = in_z;
      end
      vrot_pkg::ACT_Y: begin
        u0 = in_x;
        v0 = in_z;
      end
      default: begin
        u0 = in_x;
        v0 = in_y;
      end
    endcase

    ug = vrot_pkg::data_t'(u0) <<< vrot_pkg::GUARD_BITS;
    vg = vrot_pkg::data_t'(v0) <<< vrot_pkg::GUARD_BITS;

    // whole quarter turns done exactly
    case (quad)
      QUAD_1: begin
        rot_nxt.u = -vg;
        rot_nxt.v = ug;
      end
      QUAD_2: begin
        rot_nxt.u = -ug;
        rot_nxt.v = -vg;
      end
      QUAD_3: begin
        rot_nxt.u = vg;
        rot_nxt.v = -ug;
      end
      default: begin
        rot_nxt.u = ug;
        rot_nxt.v = vg;
      end
    endcase
    rot_nxt.z = $signed(resid);

    side_nxt.action = in_action;
    side_nxt.x      = in_x;
    side_nxt.y      = in_y;
    side_nxt.z      = in_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r  <= rot_nxt;
      side_r <= side_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/vrot_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none

module vrot_cordic (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            valid_i,
  input  wire vrot_pkg::rot_t  rot_i,
  input  wire vrot_pkg::side_t side_i,
  output logic                 valid_o,
  output vrot_pkg::rot_t       rot_o,
  output vrot_pkg::side_t      side_o
);

  logic [vrot_pkg::CORDIC_STAGES-1:0] valid_r;
  vrot_pkg::rot_t                     rot_r  [vrot_pkg::CORDIC_STAGES];
  vrot_pkg::side_t                    side_r [vrot_pkg::CORDIC_STAGES];

  for (genvar i = 0; i < vrot_pkg::CORDIC_STAGES; i++) begin : g_stage
    logic                         src_valid;
    vrot_pkg::rot_t               src;
    vrot_pkg::side_t              src_side;
    vrot_pkg::data_t              du;
    vrot_pkg::data_t              dv;
    logic [vrot_pkg::Z_WIDTH-1:0] ang;
    vrot_pkg::rot_t               rot_nxt;

    if (i == 0) begin : g_first
      assign src_valid = valid_i;
      assign src       = rot_i;
      assign src_side  = side_i;
    end else begin : g_next
      assign src_valid = valid_r[i-1];
      assign src       = rot_r[i-1];
      assign src_side  = side_r[i-1];
    end

    always_comb begin
      du  = $signed(src.v) >>> i;
      dv  = $signed(src.u) >>> i;
      ang = vrot_pkg::atan_turn(5'(i));
      if (!src.z[vrot_pkg::Z_WIDTH-1]) begin
        rot_nxt.u = src.u - du;
        rot_nxt.v = src.v + dv;
        rot_nxt.z = src.z - $signed(ang);
      end else begin
        rot_nxt.u = src.u + du;
        rot_nxt.v = src.v - dv;
        rot_nxt.z = src.z + $signed(ang);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rot_r[i]  <= rot_nxt;
        side_r[i] <= src_side;
      end
    end
  end

  assign valid_o = valid_r[vrot_pkg::CORDIC_STAGES-1];
  assign rot_o   = rot_r[vrot_pkg::CORDIC_STAGES-1];
  assign side_o  = side_r[vrot_pkg::CORDIC_STAGES-1];

endmodule

`default_nettype wire

/* design/vrot_finish.sv */
`timescale 1ns / 1ps
`default_nettype none

module vrot_finish (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            valid_i,
  input  wire vrot_pkg::rot_t  rot_i,
  input  wire vrot_pkg::side_t side_i,
  output logic                 valid_o,
  output vrot_pkg::coord_t     out_x,
  output vrot_pkg::coord_t     out_y,
  output vrot_pkg::coord_t     out_z
);

  localparam int DW = vrot_pkg::DATA_WIDTH;
  localparam int MS = vrot_pkg::MUL_SPLIT;
  localparam logic [vrot_pkg::SUM_WIDTH-1:0] RND  =
    vrot_pkg::SUM_WIDTH'(1) << (vrot_pkg::GUARD_BITS - 1);
  localparam logic [vrot_pkg::RND_WIDTH-1:0] LIM  =
    vrot_pkg::RND_WIDTH'(1) << (vrot_pkg::COORD_WIDTH - 1);
  localparam vrot_pkg::coord_t CMAX = {1'b0, {(vrot_pkg::COORD_WIDTH-1){1'b1}}};
  localparam vrot_pkg::coord_t CMIN = {1'b1, {(vrot_pkg::COORD_WIDTH-1){1'b0}}};

  function automatic vrot_pkg::coord_t sat(input logic neg,
                                           input logic [vrot_pkg::RND_WIDTH-1:0] r);
    vrot_pkg::coord_t res;
    if (neg) begin
      res = (r > LIM) ? CMIN
            : vrot_pkg::COORD_WIDTH'(vrot_pkg::RND_WIDTH'(0) - r);
    end else begin
      res = (r > LIM - vrot_pkg::RND_WIDTH'(1)) ? CMAX : vrot_pkg::COORD_WIDTH'(r);
    end
    return res;
  endfunction

  // magnitude
  logic                                valid1_r;
  logic                                neg_u1_r, neg_v1_r;
  logic [DW-1:0]                       m_u_r, m_v_r;
  vrot_pkg::side_t                     side1_r;
  // gain products
  logic                                valid2_r;
  logic                                neg_u2_r, neg_v2_r;
  logic [vrot_pkg::PH_WIDTH-1:0]       ph_u_r, ph_v_r;
  logic [MS-1:0]                       pl_u_r, pl_v_r;
  vrot_pkg::side_t                     side2_r;
  // rounded
  logic                                valid3_r;
  logic                                neg_u3_r, neg_v3_r;
  logic [vrot_pkg::RND_WIDTH-1:0]      r_u_r, r_v_r;
  vrot_pkg::side_t                     side3_r;
  // output register
  logic                                valid_o_r;
  vrot_pkg::coord_t                    out_x_r, out_y_r, out_z_r;

  logic [DW-1:0]                       m_u_nxt, m_v_nxt;
  logic [vrot_pkg::PH_WIDTH-1:0]       ph_u_nxt, ph_v_nxt;
  logic [2*MS-1:0]                     pl_u_full, pl_v_full;
  logic [vrot_pkg::SUM_WIDTH-1:0]      sum_u, sum_v;
  logic [vrot_pkg::RND_WIDTH-1:0]      r_u_nxt, r_v_nxt;
  vrot_pkg::coord_t                    fu, fv;
  vrot_pkg::coord_t                    out_x_nxt, out_y_nxt, out_z_nxt;

  always_comb begin
    m_u_nxt = rot_i.u[DW-1] ? DW'(-rot_i.u) : DW'(rot_i.u);
    m_v_nxt = rot_i.v[DW-1] ? DW'(-rot_i.v) : DW'(rot_i.v);

    ph_u_nxt  = vrot_pkg::PH_WIDTH'(m_u_r[DW-1:MS]) * vrot_pkg::PH_WIDTH'(vrot_pkg::INV_GAIN);
    ph_v_nxt  = vrot_pkg::PH_WIDTH'(m_v_r[DW-1:MS]) * vrot_pkg::PH_WIDTH'(vrot_pkg::INV_GAIN);
    pl_u_full = (2*MS)'(m_u_r[MS-1:0]) * (2*MS)'(vrot_pkg::INV_GAIN);
    pl_v_full = (2*MS)'(m_v_r[MS-1:0]) * (2*MS)'(vrot_pkg::INV_GAIN);

    sum_u   = vrot_pkg::SUM_WIDTH'(ph_u_r) + vrot_pkg::SUM_WIDTH'(pl_u_r) + RND;
    sum_v   = vrot_pkg::SUM_WIDTH'(ph_v_r) + vrot_pkg::SUM_WIDTH'(pl_v_r) + RND;
    r_u_nxt = sum_u[vrot_pkg::SUM_WIDTH-1:vrot_pkg::GUARD_BITS];
    r_v_nxt = sum_v[vrot_pkg::SUM_WIDTH-1:vrot_pkg::GUARD_BITS];

    fu = sat(neg_u3_r, r_u_r);
    fv = sat(neg_v3_r, r_v_r);

    out_x_nxt = side3_r.x;
    out_y_nxt = side3_r.y;
    out_z_nxt = side3_r.z;
    case (side3_r.action)
      vrot_pkg::ACT_X: begin
        out_y_nxt = fu;
        out_z_nxt = fv;
      end
      vrot_pkg::ACT_Y: begin
        out_x_nxt = fu;
        out_z_nxt = fv;
      end
      vrot_pkg::ACT_Z: begin
        out_x_nxt = fu;
        out_y_nxt = fv;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r  <= 1'b0;
      valid2_r  <= 1'b0;
      valid3_r  <= 1'b0;
      valid_o_r <= 1'b0;
    end else if (en) begin
      valid1_r  <= valid_i;
      valid2_r  <= valid1_r;
      valid3_r  <= valid2_r;
      valid_o_r <= valid3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_u1_r <= rot_i.u[DW-1];
      neg_v1_r <= rot_i.v[DW-1];
      m_u_r    <= m_u_nxt;
      m_v_r    <= m_v_nxt;
      side1_r  <= side_i;

      neg_u2_r <= neg_u1_r;
      neg_v2_r <= neg_v1_r;
      ph_u_r   <= ph_u_nxt;
      ph_v_r   <= ph_v_nxt;
      pl_u_r   <= pl_u_full[2*MS-1:MS];
      pl_v_r   <= pl_v_full[2*MS-1:MS];
      side2_r  <= side1_r;

      neg_u3_r <= neg_u2_r;
      neg_v3_r <= neg_v2_r;
      r_u_r    <= r_u_nxt;
      r_v_r    <= r_v_nxt;
      side3_r  <= side2_r;

      out_x_r  <= out_x_nxt;
      out_y_r  <= out_y_nxt;
      out_z_r  <= out_z_nxt;
    end
  end

  assign valid_o = valid_o_r;
  assign out_x   = out_x_r;
  assign out_y   = out_y_r;
  assign out_z   = out_z_r;

`ifndef SYNTHESIS
  a_fin_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (en && valid1_r) |=> valid2_r)
    else $error("vrot_finish: transaction dropped between magnitude and product stages");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({valid1_r, valid2_r, valid3_r, valid_o_r}))
    else $error("vrot_finish: valid bits moved during stall");

  a_fin_mag: assert property (@(posedge clk) disable iff (!rst_n)
    valid1_r |-> (!m_u_r[DW-1] && !m_v_r[DW-1]))
    else $error("vrot_finish: magnitude exceeds datapath headroom");
`endif

endmodule

`default_nettype wire

/* design/axis_vector_rotation.sv */
`timescale 1ns / 1ps
`default_nettype none

// Rotates a Q16.16 vertex about the x, y or z axis (in_action 0/1/2; 3 passes
// the vertex through) by in_turn_angle, a binary fraction of a full turn.
// Quarter turns are applied exactly, the remainder by a 24-stage CORDIC with
// gain compensation, round half away from zero and saturation. One
// transaction is accepted per clock while in_ready is high; the pipeline has
// 1 quadrant stage, 24 CORDIC stages and 4 gain/round/saturate stages ending
// in the output register. The whole pipeline advances together: a stalled
// output with valid held freezes every stage, so in_ready follows out_ready
// through that enable.

module axis_vector_rotation (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_action,
  input  wire vrot_pkg::coord_t                 in_x,
  input  wire vrot_pkg::coord_t                 in_y,
  input  wire vrot_pkg::coord_t                 in_z,
  input  wire logic [vrot_pkg::ANGLE_WIDTH-1:0] in_turn_angle,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output vrot_pkg::coord_t                      out_x,
  output vrot_pkg::coord_t                      out_y,
  output vrot_pkg::coord_t                      out_z
);

  logic            en;
  logic            prep_valid;
  vrot_pkg::rot_t  prep_rot;
  vrot_pkg::side_t prep_side;
  logic            cor_valid;
  vrot_pkg::rot_t  cor_rot;
  vrot_pkg::side_t cor_side;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  vrot_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .in_action     (in_action),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_z          (in_z),
    .in_turn_angle (in_turn_angle),
    .valid_r       (prep_valid),
    .rot_r         (prep_rot),
    .side_r        (prep_side)
  );

  vrot_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (prep_valid),
    .rot_i   (prep_rot),
    .side_i  (prep_side),
    .valid_o (cor_valid),
    .rot_o   (cor_rot),
    .side_o  (cor_side)
  );

  vrot_finish u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (cor_valid),
    .rot_i   (cor_rot),
    .side_i  (cor_side),
    .valid_o (out_valid),
    .out_x   (out_x),
    .out_y   (out_y),
    .out_z   (out_z)
  );

endmodule

`default_nettype wire
